// ===== rtl/core/swcr_pkg.sv =====
// Package for the swept circle / rectangle hit distance block: shared constants.
package swcr_pkg;

  // Default coordinate width: signed fixed point, 4 fraction bits.
  localparam int unsigned COORD_BITS_DEF = 16;

  // Legal range of the coordinate width.
  localparam int unsigned COORD_BITS_MIN = 8;
  localparam int unsigned COORD_BITS_MAX = 32;

endpackage

// ===== rtl/core/swcr_front.sv =====
// Front stages: span gaps, overlap test, contact offset and r*r - dy*dy.
module swcr_front #(
  parameter int unsigned CoordBits = swcr_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [CoordBits-1:0]        circle_x_i,
  input  logic [CoordBits-1:0]        circle_y_i,
  input  logic [CoordBits-2:0]        radius_i,
  input  logic [CoordBits-1:0]        rect_left_i,
  input  logic [CoordBits-1:0]        rect_bottom_i,
  input  logic [CoordBits-2:0]        rect_height_i,
  output logic                        valid_o,
  output logic                        miss_o,
  output logic [CoordBits-1:0]        cx_o,
  output logic [CoordBits-1:0]        left_o,
  output logic [2*(CoordBits-1)-1:0]  prod_o
);

  localparam int unsigned W = CoordBits;
  localparam int unsigned N = CoordBits - 1;
  localparam int unsigned G = CoordBits + 2;

  // stage 1: gaps between circle centre and rectangle span ends
  logic signed [G-1:0] cy_ext, bot_ext;
  logic signed [G-1:0] lo_gap_d, hi_gap_d;
  logic signed [G-1:0] s1_lo_gap_q, s1_hi_gap_q;
  logic [N-1:0]        s1_r_q;
  logic [W-1:0]        s1_cx_q, s1_left_q;
  logic                s1_valid_q;

  assign cy_ext   = $signed({{2{circle_y_i[W-1]}}, circle_y_i});
  assign bot_ext  = $signed({{2{rect_bottom_i[W-1]}}, rect_bottom_i});
  assign lo_gap_d = bot_ext - cy_ext;
  assign hi_gap_d = cy_ext - bot_ext - $signed({3'b000, rect_height_i});

  // stage 2: overlap test and |dy|
  logic signed [G-1:0] r_ext;
  logic                lo_pos, hi_pos;
  logic                miss_d;
  logic [N-1:0]        dy_d;
  logic [N-1:0]        s2_dy_q, s2_r_q;
  logic [W-1:0]        s2_cx_q, s2_left_q;
  logic                s2_miss_q, s2_valid_q;

  assign r_ext  = $signed({3'b000, s1_r_q});
  assign lo_pos = !s1_lo_gap_q[G-1] && (|s1_lo_gap_q);
  assign hi_pos = !s1_hi_gap_q[G-1] && (|s1_hi_gap_q);
  // circle top below rect bottom, or circle bottom above rect top
  assign miss_d = (s1_lo_gap_q > r_ext) || (s1_hi_gap_q > r_ext);

  always_comb begin
    priority if (lo_pos) begin
      dy_d = s1_lo_gap_q[N-1:0];
    end else if (hi_pos) begin
      dy_d = s1_hi_gap_q[N-1:0];
    end else begin
      dy_d = '0;
    end
  end

  // stage 3: r - dy and r + dy, so that one product gives r*r - dy*dy
  logic [N-1:0] s3_rm_q;
  logic [N:0]   s3_rp_q;
  logic [W-1:0] s3_cx_q, s3_left_q;
  logic         s3_miss_q, s3_valid_q;

  // stage 4: product
  logic [2*N:0]   prod_full;
  logic [2*N-1:0] s4_prod_q;
  logic [W-1:0]   s4_cx_q, s4_left_q;
  logic           s4_miss_q, s4_valid_q;

  assign prod_full = (2*N+1)'(s3_rm_q) * (2*N+1)'(s3_rp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_lo_gap_q <= lo_gap_d;
      s1_hi_gap_q <= hi_gap_d;
      s1_r_q      <= radius_i;
      s1_cx_q     <= circle_x_i;
      s1_left_q   <= rect_left_i;

      s2_miss_q   <= miss_d;
      s2_dy_q     <= dy_d;
      s2_r_q      <= s1_r_q;
      s2_cx_q     <= s1_cx_q;
      s2_left_q   <= s1_left_q;

      s3_rm_q     <= s2_r_q - s2_dy_q;
      s3_rp_q     <= {1'b0, s2_r_q} + {1'b0, s2_dy_q};
      s3_miss_q   <= s2_miss_q;
      s3_cx_q     <= s2_cx_q;
      s3_left_q   <= s2_left_q;

      // value is below 2^(2N) whenever the pair overlaps
      s4_prod_q   <= prod_full[2*N-1:0];
      s4_miss_q   <= s3_miss_q;
      s4_cx_q     <= s3_cx_q;
      s4_left_q   <= s3_left_q;
    end
  end

  assign valid_o = s4_valid_q;
  assign miss_o  = s4_miss_q;
  assign cx_o    = s4_cx_q;
  assign left_o  = s4_left_q;
  assign prod_o  = s4_prod_q;

endmodule

// ===== rtl/core/swcr_sqrt_step.sv =====
// One registered digit step of the floor square root (one root bit per stage).
module swcr_sqrt_step #(
  parameter int unsigned CoordBits = swcr_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic                        miss_i,
  input  logic [CoordBits-1:0]        cx_i,
  input  logic [CoordBits-1:0]        left_i,
  input  logic [CoordBits-2:0]        rem_i,
  input  logic [CoordBits-2:0]        root_i,
  input  logic [2*(CoordBits-1)-1:0]  rad_i,
  output logic                        valid_o,
  output logic                        miss_o,
  output logic [CoordBits-1:0]        cx_o,
  output logic [CoordBits-1:0]        left_o,
  output logic [CoordBits-2:0]        rem_o,
  output logic [CoordBits-2:0]        root_o,
  output logic [2*(CoordBits-1)-1:0]  rad_o
);

  localparam int unsigned N = CoordBits - 1;

  logic [N+1:0] rem_sh, trial, rem_sub;
  logic         ge;

  // bring down the next two radicand bits, try root*4 + 1
  assign rem_sh  = {rem_i, rad_i[2*N-1 -: 2]};
  assign trial   = {root_i, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  logic             valid_q, miss_q;
  logic [N-1:0]     rem_q, root_q;
  logic [2*N-1:0]   rad_q;
  logic [CoordBits-1:0] cx_q, left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // remainder is at most twice the partial root: fits N bits wherever a later
      // step reads it (the last step's remainder is not used)
      rem_q  <= ge ? rem_sub[N-1:0] : rem_sh[N-1:0];
      root_q <= {root_i[N-2:0], ge};
      rad_q  <= {rad_i[2*N-3:0], 2'b00};
      miss_q <= miss_i;
      cx_q   <= cx_i;
      left_q <= left_i;
    end
  end

  assign valid_o = valid_q;
  assign miss_o  = miss_q;
  assign cx_o    = cx_q;
  assign left_o  = left_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign rad_o   = rad_q;

endmodule

// ===== rtl/core/swcr_out.sv =====
// Output stage: contact x against the left edge, hit flag and distance word.
module swcr_out #(
  parameter int unsigned CoordBits = swcr_pkg::COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic                  miss_i,
  input  logic [CoordBits-1:0]  cx_i,
  input  logic [CoordBits-1:0]  left_i,
  input  logic [CoordBits-2:0]  root_i,
  output logic                  valid_o,
  output logic                  hit_o,
  output logic [CoordBits:0]    distance_o
);

  localparam int unsigned W = CoordBits;
  localparam int unsigned G = CoordBits + 2;

  logic signed [G-1:0] diff;
  logic                hit_d;

  // left - (cx + root); a hit needs it strictly positive
  assign diff  = $signed({{2{left_i[W-1]}}, left_i}) - $signed({{2{cx_i[W-1]}}, cx_i})
               - $signed({3'b000, root_i});
  assign hit_d = !miss_i && !diff[G-1] && (|diff);

  logic           valid_q, hit_q;
  logic [W:0]     distance_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q      <= hit_d;
      distance_q <= hit_d ? diff[W:0] : '0;
    end
  end

  assign valid_o    = valid_q;
  assign hit_o      = hit_q;
  assign distance_o = distance_q;

endmodule

// ===== rtl/core/swept_circle_rect_hit_distance.sv =====
// Top level: pipelined swept circle vs rectangle hit test and travel distance.
//
//   word     direction  handshake                 payload
//   input    in         in_valid_i / in_stall_o   circle_x, circle_y, radius,
//                                                 rect_left, rect_bottom, rect_height
//   result   out        out_valid_o / out_stall_i hit, distance
//
// One word per cycle while out_stall_i does not hold the output. Stages: four front
// stages, one square root stage per root bit (COORD_BITS - 1), one output register.
// The whole pipeline advances together; it freezes only while the output word is
// held by out_stall_i, and in_stall_o is raised in exactly those cycles.
// Reset clears the valid bits of every stage; payload registers are not reset.
module swept_circle_rect_hit_distance #(
  parameter int unsigned COORD_BITS = swcr_pkg::COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] circle_x_i,
  input  logic [COORD_BITS-1:0] circle_y_i,
  input  logic [COORD_BITS-2:0] radius_i,
  input  logic [COORD_BITS-1:0] rect_left_i,
  input  logic [COORD_BITS-1:0] rect_bottom_i,
  input  logic [COORD_BITS-2:0] rect_height_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output logic [COORD_BITS:0]   distance_o
);

  localparam int unsigned W = COORD_BITS;
  localparam int unsigned N = COORD_BITS - 1;

  logic en;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // square root taps: index 0 is the front output, index N the last step
  logic           sq_valid [N+1];
  logic           sq_miss  [N+1];
  logic [W-1:0]   sq_cx    [N+1];
  logic [W-1:0]   sq_left  [N+1];
  logic [N-1:0]   sq_rem   [N+1];
  logic [N-1:0]   sq_root  [N+1];
  logic [2*N-1:0] sq_rad   [N+1];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  swcr_front #(
    .CoordBits(COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .circle_x_i   (circle_x_i),
    .circle_y_i   (circle_y_i),
    .radius_i     (radius_i),
    .rect_left_i  (rect_left_i),
    .rect_bottom_i(rect_bottom_i),
    .rect_height_i(rect_height_i),
    .valid_o      (sq_valid[0]),
    .miss_o       (sq_miss[0]),
    .cx_o         (sq_cx[0]),
    .left_o       (sq_left[0]),
    .prod_o       (sq_rad[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_sqrt
    swcr_sqrt_step #(
      .CoordBits(COORD_BITS)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(sq_valid[k]),
      .miss_i (sq_miss[k]),
      .cx_i   (sq_cx[k]),
      .left_i (sq_left[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rad_i  (sq_rad[k]),
      .valid_o(sq_valid[k+1]),
      .miss_o (sq_miss[k+1]),
      .cx_o   (sq_cx[k+1]),
      .left_o (sq_left[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .rad_o  (sq_rad[k+1])
    );
  end

  swcr_out #(
    .CoordBits(COORD_BITS)
  ) u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (sq_valid[N]),
    .miss_i    (sq_miss[N]),
    .cx_i      (sq_cx[N]),
    .left_i    (sq_left[N]),
    .root_i    (sq_root[N]),
    .valid_o   (out_valid_o),
    .hit_o     (hit_o),
    .distance_o(distance_o)
  );

  // a miss carries a zero distance, a hit a nonzero one
  a_hit_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_o == (distance_o != '0)))
    else $error("hit flag and distance disagree");

  // left - contact x never reaches 2^COORD_BITS
  a_dist_msb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !distance_o[W])
    else $error("distance out of range");

  // a held result keeps the whole pipeline frozen, including the last root tap
  a_hold_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(sq_root[N]) && $stable(sq_valid[N])))
    else $error("pipeline moved while output held");

  // a valid word at the front output moves into the first root step
  a_front_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && sq_valid[0]) |=> (sq_valid[1] || !en))
    else $error("valid bit lost in square root pipeline");

endmodule
